/* sv/isci_pkg.sv */
// ----------------------------------------------------------------------------
// isci_pkg
// Types and codes shared by the coalescing interval set insert block.
// ----------------------------------------------------------------------------
package isci_pkg;

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_READ   = 1'b1;

   localparam logic [2:0] ST_STORED     = 3'd0;
   localparam logic [2:0] ST_MERGE_L    = 3'd1;
   localparam logic [2:0] ST_MERGE_R    = 3'd2;
   localparam logic [2:0] ST_MERGE_LR   = 3'd3;
   localparam logic [2:0] ST_DUP_KEPT   = 3'd4;
   localparam logic [2:0] ST_FULL       = 3'd5;
   localparam logic [2:0] ST_READ_OK    = 3'd6;
   localparam logic [2:0] ST_READ_RANGE = 3'd7;

   typedef struct packed {
      logic        func;
      logic [31:0] range_lo;
      logic [31:0] range_hi;
      logic [7:0]  read_index;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] entry_lo;
      logic [31:0] entry_hi;
      logic [8:0]  entry_count;
   } rsp_type;

   typedef struct packed {
      logic [31:0] lo;
      logic [31:0] hi;
   } range_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_RIGHT_CHK,
      S_DECIDE,
      S_INS_RD,
      S_INS_WR,
      S_REM_RD,
      S_REM_WR,
      S_READ_WAIT,
      S_DONE
   } state_type;

endpackage

/* sv/isci_mem.sv */
// ----------------------------------------------------------------------------
// isci_mem
// Range table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module isci_mem #(
   parameter int AW = 8
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  isci_pkg::range_type wr_data,
   input  logic               rd_en,
   input  logic [AW-1:0]      rd_addr,
   output isci_pkg::range_type rd_data
);
   import isci_pkg::*;

   range_type mem_ff [2**AW];
   range_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/interval_set_coalescing_insert_top.sv */
// ----------------------------------------------------------------------------
// interval_set_coalescing_insert_top
// Sorted range table with coalescing insert and indexed read.
// ----------------------------------------------------------------------------
// Usage:
//  req_ channel carries one transaction per command (insert or read); rsp_
//  channel returns exactly one transaction per command, in order.
//  Accept: valid high and stall low at a rising clock edge.
//  One command is worked at a time; req_stall is low only when idle.
//  The table lives in a single-port-read memory, so each step is a read
//  followed by a compare or write in the next cycle.
//  Read: one memory read, then the result (an out-of-range index goes
//  straight to the result). Insert: a linear search to the position,
//  then a read and a write per entry moved when opening or closing a gap
//  (up to the table occupancy), with accept, decide and finish steps.
//  Reset (synchronous) empties the table at once; memory contents are
//  not cleared, since only entries below the fill count are ever read.
//  A finished result waits in an output register while rsp_stall is high;
//  the next command may already be accepted and worked, but it cannot
//  complete until that result has been taken.
// ----------------------------------------------------------------------------
module interval_set_coalescing_insert_top #(
   parameter int ENTRIES = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  isci_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output isci_pkg::rsp_type rsp_payload
);
   import isci_pkg::*;

   localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW = $clog2(ENTRIES + 1);

   state_type state_ff, state_in;

   logic [CW-1:0] count_ff, count_in;   // fill count
   logic [CW-1:0] idx_ff, idx_in;       // search position, then pos
   logic [CW-1:0] j_ff, j_in;           // shift cursor
   logic [1:0]    k_ff, k_in;           // entries removed
   req_type       cmd_ff, cmd_in;
   range_type     prev_ff, prev_in;     // left neighbour
   range_type     cur_ff, cur_in;       // entry at pos
   range_type     right_ff, right_in;   // right neighbour
   logic          dup_ff, dup_in;
   logic          rvld_ff, rvld_in;

   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;
   logic [2:0]    res_status_ff, res_status_in;
   range_type     res_ff, res_in;

   logic          wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;
   range_type     wr_data, rd_data;

   logic          ml, mr, full;
   logic [31:0]   nhi;

   isci_mem #(.AW(AW)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Merge tests on 33 bits so no wrap
   assign ml   = (idx_ff != '0) &&
                 (({1'b0, prev_ff.hi} + 33'd1) == {1'b0, cmd_ff.range_lo});
   assign mr   = rvld_ff &&
                 ({1'b0, right_ff.lo} == ({1'b0, cmd_ff.range_hi} + 33'd1));
   assign full = (32'(count_ff) >= 32'(ENTRIES));
   assign nhi  = mr ? right_ff.hi : cmd_ff.range_hi;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      j_ff          <= j_in;
      k_ff          <= k_in;
      cmd_ff        <= cmd_in;
      prev_ff       <= prev_in;
      cur_ff        <= cur_in;
      right_ff      <= right_in;
      dup_ff        <= dup_in;
      rvld_ff       <= rvld_in;
      rsp_ff        <= rsp_in;
      res_status_ff <= res_status_in;
      res_ff        <= res_in;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      j_in          = j_ff;
      k_in          = k_ff;
      cmd_in        = cmd_ff;
      prev_in       = prev_ff;
      cur_in        = cur_ff;
      right_in      = right_ff;
      dup_in        = dup_ff;
      rvld_in       = rvld_ff;
      res_status_in = res_status_ff;
      res_in        = res_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      req_stall     = (state_ff != S_IDLE);
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;
      rd_en         = 1'b0;
      rd_addr       = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in = req_payload;
               idx_in = '0;
               if (req_payload.func == FUNC_READ) begin
                  if (32'(req_payload.read_index) < 32'(count_ff)) begin
                     rd_en    = 1'b1;
                     rd_addr  = AW'(req_payload.read_index);
                     state_in = S_READ_WAIT;
                  end else begin
                     res_status_in = ST_READ_RANGE;
                     res_in        = '0;
                     state_in      = S_DONE;
                  end
               end else begin
                  state_in = S_SCAN_RD;
               end
            end
         end
         S_READ_WAIT: begin
            res_status_in = ST_READ_OK;
            res_in        = rd_data;
            state_in      = S_DONE;
         end
         S_SCAN_RD: begin
            if (idx_ff == count_ff) begin
               dup_in   = 1'b0;
               rvld_in  = 1'b0;
               state_in = S_DECIDE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = idx_ff[AW-1:0];
               state_in = S_SCAN_CHK;
            end
         end
         S_SCAN_CHK: begin
            if (rd_data.lo < cmd_ff.range_lo) begin
               prev_in  = rd_data;
               idx_in   = idx_ff + CW'(1);
               state_in = S_SCAN_RD;
            end else begin
               cur_in = rd_data;
               if (rd_data.lo == cmd_ff.range_lo) begin
                  dup_in = 1'b1;
                  if (({1'b0, idx_ff} + (CW+1)'(1)) < {1'b0, count_ff}) begin
                     rd_en    = 1'b1;
                     rd_addr  = AW'(idx_ff + CW'(1));
                     state_in = S_RIGHT_CHK;
                  end else begin
                     rvld_in  = 1'b0;
                     state_in = S_DECIDE;
                  end
               end else begin
                  dup_in   = 1'b0;
                  right_in = rd_data;
                  rvld_in  = 1'b1;
                  state_in = S_DECIDE;
               end
            end
         end
         S_RIGHT_CHK: begin
            right_in = rd_data;
            rvld_in  = 1'b1;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (!dup_ff && full) begin
               res_status_in = ST_FULL;
               res_in        = '0;
               state_in      = S_DONE;
            end else if (!ml && !mr) begin
               if (dup_ff) begin
                  res_status_in = ST_DUP_KEPT;
                  res_in        = cur_ff;
                  state_in      = S_DONE;
               end else begin
                  res_status_in = ST_STORED;
                  res_in.lo     = cmd_ff.range_lo;
                  res_in.hi     = cmd_ff.range_hi;
                  j_in          = count_ff;
                  state_in      = S_INS_RD;
               end
            end else begin
               res_status_in = (ml && mr) ? ST_MERGE_LR : (ml ? ST_MERGE_L : ST_MERGE_R);
               wr_en         = 1'b1;
               wr_data.hi    = nhi;
               if (ml) begin
                  wr_addr    = AW'(idx_ff - CW'(1));
                  wr_data.lo = prev_ff.lo;
               end else begin
                  wr_addr    = dup_ff ? AW'(idx_ff + CW'(1)) : idx_ff[AW-1:0];
                  wr_data.lo = cmd_ff.range_lo;
               end
               res_in = wr_data;
               k_in   = {1'b0, ml && mr} + {1'b0, dup_ff};
               j_in   = idx_ff;
               if ((ml && mr) || dup_ff) begin
                  state_in = S_REM_RD;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_INS_RD: begin
            if (j_ff == idx_ff) begin
               wr_en      = 1'b1;
               wr_addr    = idx_ff[AW-1:0];
               wr_data.lo = cmd_ff.range_lo;
               wr_data.hi = cmd_ff.range_hi;
               count_in   = count_ff + CW'(1);
               state_in   = S_DONE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = AW'(j_ff - CW'(1));
               state_in = S_INS_WR;
            end
         end
         S_INS_WR: begin
            wr_en    = 1'b1;
            wr_addr  = j_ff[AW-1:0];
            wr_data  = rd_data;
            j_in     = j_ff - CW'(1);
            state_in = S_INS_RD;
         end
         S_REM_RD: begin
            if (({1'b0, j_ff} + (CW+1)'(k_ff)) >= {1'b0, count_ff}) begin
               count_in = count_ff - CW'(k_ff);
               state_in = S_DONE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = AW'(j_ff + CW'(k_ff));
               state_in = S_REM_WR;
            end
         end
         S_REM_WR: begin
            wr_en    = 1'b1;
            wr_addr  = j_ff[AW-1:0];
            wr_data  = rd_data;
            j_in     = j_ff + CW'(1);
            state_in = S_REM_RD;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in       = 1'b1;
               rsp_in.status      = res_status_ff;
               rsp_in.entry_lo    = res_ff.lo;
               rsp_in.entry_hi    = res_ff.hi;
               rsp_in.entry_count = 9'(count_ff);
               state_in           = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   // Fill count never passes table depth
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(ENTRIES))
      else $error("fill count above table depth");

   // Fill count moves only at the end of a gap open or close
   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_INS_RD && state_ff != S_REM_RD) |=> $stable(count_ff))
      else $error("fill count changed outside a shift");

   // A new result is loaded only when the output register is free
   a_rsp_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && rsp_valid_ff && rsp_stall) |=> (state_ff == S_DONE))
      else $error("result finished over a pending one");
`endif

endmodule
